>>> sv/lrc_pkg.sv
// Package for the LRU result cache: controller state encoding and fixed field widths.
// No dependencies; imported by lru_result_cache_top.
`default_nettype none
package lrc_pkg;

	localparam int CAP_W      = 7;
	localparam int KEY_W      = 64;
	localparam int HANDLE_W   = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_UPDATE = 6'b000100,
		ST_RANK   = 6'b001000,
		ST_TRIM   = 6'b010000,
		ST_RESP   = 6'b100000
	} lrc_state_t;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

endpackage
`default_nettype wire

>>> sv/lrc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; used for the entry (key and payload) and rank stores of the cache.
`default_nettype none
module lrc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> sv/lru_result_cache_top.sv
// Top level of the fully associative LRU result cache.
// Depends on lrc_pkg and lrc_ram (entry store for key and payload, rank store).
`default_nettype none
// How to use this block:
// A request enters on in_valid/in_stall with func (lookup or insert), the two
// 64-bit key halves and a payload handle. A request is taken at a clock edge
// where in_valid is high and in_stall is low. Each request yields exactly one
// response on out_valid/out_stall carrying hit, payload_out and evicted.
// The block handles one request at a time. A request first scans the entry
// store, one entry per cycle through the registered read port. A lookup miss
// then loads its response. A hit or an insert needs a second pass over the
// rank store to rewrite the recency ranks before its response is loaded, and
// the next request can be taken once the block is back in idle. With capacity
// zero a request skips the scan and goes straight to the response state.
// When the receiver stalls, the response register holds its value and a
// finished request waits in the response state, with in_stall high, until the
// register frees up. Reset clears the valid marks and the entry count and sets
// the capacity to 64; the RAMs are not cleared, since entries are only read
// once their valid mark is set. The user must write the capacity through
// cap_we and cap_wdata only while no request is in flight; the block itself
// does not enforce this. in_stall is high in a write cycle. Lowering the
// capacity below the entry count starts a pass that drops the least recent
// entries, and in_stall stays high until that pass has ended.
module lru_result_cache_top #(
	parameter int ENTRIES      = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cap_we,
	input  wire logic [lrc_pkg::CAP_W-1:0]        cap_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             func,
	input  wire logic [lrc_pkg::KEY_W-1:0]        key_prefix,
	input  wire logic [lrc_pkg::KEY_W-1:0]        key_params,
	input  wire logic [lrc_pkg::HANDLE_W-1:0]     payload_in,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  hit,
	output logic      [lrc_pkg::HANDLE_W-1:0]     payload_out,
	output logic                                  evicted
);

	import lrc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int KW2   = 2 * KEY_W;
	localparam int EW    = KW2 + PAYLOAD_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// Clamp the capacity register to the table size.
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		if (int'(c) > ENTRIES) begin
			return CNT_W'(ENTRIES);
		end
		return CNT_W'(c);
	endfunction

	lrc_state_t state_q;

	logic [CAP_W-1:0]        cap_q;
	logic [ENTRIES-1:0]      valid_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        trim_cap_q;

	// Latched request.
	logic                    func_q;
	logic [KW2-1:0]          key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// Scan bookkeeping.
	logic [IDX_W-1:0]        scan_idx_q;
	logic                    issue_q;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    rd_vld_s1;
	logic                    found_q;
	logic [IDX_W-1:0]        hit_slot_q;
	logic [IDX_W-1:0]        hit_rank_q;
	logic [PAYLOAD_BITS-1:0] hit_pay_q;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_slot_q;

	// Response register.
	logic                    res_hit_q, res_ev_q;
	logic [HANDLE_W-1:0]     res_pay_q;
	logic                    out_valid_q, hit_q, evicted_q;
	logic [HANDLE_W-1:0]     payload_out_q;

	logic [CNT_W-1:0]        cap_eff;
	logic [CNT_W-1:0]        cap_lru;
	logic                    full;
	logic [EW-1:0]           ent_wdata, ent_rdata;
	logic [KW2-1:0]          key_rdata;
	logic [PAYLOAD_BITS-1:0] pay_rdata;
	logic                    ent_we;
	logic [IDX_W-1:0]        ent_waddr;
	logic                    rank_we;
	logic [IDX_W-1:0]        rank_wdata, rank_rdata;
	logic                    in_take;
	logic                    out_free;
	logic                    resp_load;
	logic                    pass_end;
	logic                    trim_start;
	logic                    row_valid;
	logic                    rd_match, rd_free;
	logic                    miss_ins, ev_now;
	logic                    rank_row, row_new, row_hit, row_victim, row_bump;
	logic                    trim_drop;
	logic [CNT_W-1:0]        new_cap_eff;

	assign cap_eff     = eff_cap(cap_q);
	assign cap_lru     = cap_eff - CNT_W'(1);
	assign full        = (count_q >= cap_eff);
	assign new_cap_eff = eff_cap(cap_wdata);

	// A capacity write takes the cycle, so no request is taken alongside it.
	assign in_stall  = (state_q != ST_IDLE) || cap_we;
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign resp_load = (state_q == ST_RESP) && out_free;
	assign trim_start = cap_we && (state_q == ST_IDLE) && (cap_wdata != cap_q)
		&& (count_q > new_cap_eff);

	// A read result belongs to the entry addressed in the previous cycle.
	assign pass_end  = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
	assign row_valid = valid_q[rd_idx_s1];
	assign key_rdata = ent_rdata[EW-1 -: KW2];
	assign pay_rdata = ent_rdata[PAYLOAD_BITS-1:0];
	assign rd_match  = rd_vld_s1 && row_valid && (key_rdata == key_q);
	assign rd_free   = rd_vld_s1 && (!row_valid
		|| (full && (CNT_W'(rank_rdata) >= cap_lru)));

	assign miss_ins = (func_q == FUNC_INSERT) && !found_q;
	assign ev_now   = miss_ins && full;

	// An insert writes the whole entry; on a hit the key is unchanged.
	assign ent_we    = (state_q == ST_UPDATE) && (func_q == FUNC_INSERT);
	assign ent_waddr = found_q ? hit_slot_q : free_slot_q;
	assign ent_wdata = {key_q, pay_q};

	// Rank pass: the hit entry or the new entry becomes most recent, the
	// entries ahead of it move back by one and an eviction drops the last one.
	assign rank_row   = (state_q == ST_RANK) && rd_vld_s1;
	assign row_new    = miss_ins && (rd_idx_s1 == free_slot_q);
	assign row_hit    = found_q && (rd_idx_s1 == hit_slot_q);
	assign row_victim = res_ev_q && row_valid && !row_new
		&& (CNT_W'(rank_rdata) >= cap_lru);
	assign row_bump   = found_q ? (row_valid && (rank_rdata < hit_rank_q))
		: (row_valid && !row_victim);
	assign rank_we    = rank_row && (row_new || row_hit || row_bump);
	assign rank_wdata = (row_new || row_hit) ? '0 : rank_rdata + IDX_W'(1);

	// Trim pass after a capacity decrease.
	assign trim_drop = (state_q == ST_TRIM) && rd_vld_s1 && row_valid
		&& (CNT_W'(rank_rdata) >= trim_cap_q);

	lrc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (scan_idx_q),
		.rdata (ent_rdata)
	);

	lrc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rd_idx_s1),
		.wdata (rank_wdata),
		.raddr (scan_idx_q),
		.rdata (rank_rdata)
	);

	// Request capture, scan and rank passes, result forming.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_q;
			rd_idx_s1 <= scan_idx_q;
			// Every pass walks the address from zero to the last entry.
			if (issue_q) begin
				if (scan_idx_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (trim_start) begin
						trim_cap_q <= new_cap_eff;
						scan_idx_q <= '0;
						issue_q    <= 1'b1;
						state_q    <= ST_TRIM;
					end else if (in_take) begin
						func_q       <= func;
						key_q        <= {key_prefix, key_params};
						pay_q        <= PAYLOAD_BITS'(payload_in);
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						scan_idx_q   <= '0;
						res_hit_q    <= 1'b0;
						res_ev_q     <= 1'b0;
						res_pay_q    <= '0;
						if (cap_eff == '0) begin
							state_q <= ST_RESP;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_match && !found_q) begin
						found_q    <= 1'b1;
						hit_slot_q <= rd_idx_s1;
						hit_rank_q <= rank_rdata;
						hit_pay_q  <= pay_rdata;
					end
					if (rd_free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_slot_q  <= rd_idx_s1;
					end
					if (pass_end) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					res_hit_q <= found_q;
					res_ev_q  <= ev_now;
					res_pay_q <= (found_q && (func_q == FUNC_LOOKUP))
						? HANDLE_W'(hit_pay_q) : '0;
					if (found_q || miss_ins) begin
						scan_idx_q <= '0;
						issue_q    <= 1'b1;
						state_q    <= ST_RANK;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RANK: begin
					if (pass_end) begin
						state_q <= ST_RESP;
					end
				end
				ST_TRIM: begin
					if (pass_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q   <= 1'b1;
			hit_q         <= res_hit_q;
			evicted_q     <= res_ev_q;
			payload_out_q <= res_pay_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Valid marks, entry count and capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			valid_q <= '0;
		end else begin
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
			if (trim_drop) begin
				valid_q[rd_idx_s1] <= 1'b0;
				count_q            <= count_q - CNT_W'(1);
			end else if ((state_q == ST_UPDATE) && miss_ins && !full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rank_row && row_new) begin
				valid_q[rd_idx_s1] <= 1'b1;
			end else if (rank_row && row_victim) begin
				valid_q[rd_idx_s1] <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign evicted     = evicted_q;
	assign payload_out = payload_out_q;

	// The valid marks and the entry count agree whenever no pass is running.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_RESP)
		|-> ($countones(valid_q) == int'(count_q)))
		else $error("entry count disagrees with valid marks");

	// Outside idle and the trim pass, the table never holds more than the effective capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_TRIM) |-> (count_q <= cap_eff))
		else $error("entry count above capacity");

	// A miss-insert always finds a free or victim slot by the end of the scan.
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && miss_ins) |-> free_found_q)
		else $error("no slot for new entry");

	// An eviction never comes with a hit, and a nonzero handle implies a hit.
	a_resp_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!(hit_q && evicted_q) && (hit_q || payload_out_q == '0)))
		else $error("inconsistent response fields");

endmodule
`default_nettype wire
